/* rtl/mtv_pkg.sv */
// Package for the two-voice step-tone player.
// Holds the parser command type, event codes, period table and lookup function.
// Depends on nothing.
package mtv_pkg;

  localparam int unsigned NOTE_W = 7;
  localparam int unsigned PER_W  = 18;
  localparam int unsigned ROM_N  = 116;

  localparam logic [7:0]        NOTE_ON     = 8'h90;
  localparam logic [3:0]        SYS_NIBBLE  = 4'hF;
  localparam logic [NOTE_W-1:0] LOW_NOTE    = 7'd12;
  localparam logic [NOTE_W-1:0] SPLIT_RESET = 7'd55;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PLACED   = 3'd1,
    EV_RELEASED = 3'd2,
    EV_UNKNOWN  = 3'd3,
    EV_SYSTEM   = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_TICK,
    CMD_PLACE,
    CMD_RELEASE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [NOTE_W-1:0] note;
    event_t            ev;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [PER_W-1:0] PERIOD_ROM [0:ROM_N-1] = '{
    18'd145455, 18'd137291, 18'd129585, 18'd122312, 18'd115447, 18'd108968,
    18'd102852, 18'd97079,  18'd91631,  18'd86488,  18'd81634,  18'd77052,
    18'd72727,  18'd68645,  18'd64793,  18'd61156,  18'd57724,  18'd54484,
    18'd51426,  18'd48540,  18'd45815,  18'd43244,  18'd40817,  18'd38526,
    18'd36364,  18'd34323,  18'd32396,  18'd30578,  18'd28862,  18'd27242,
    18'd25713,  18'd24270,  18'd22908,  18'd21622,  18'd20408,  18'd19263,
    18'd18182,  18'd17161,  18'd16198,  18'd15289,  18'd14431,  18'd13621,
    18'd12856,  18'd12135,  18'd11454,  18'd10811,  18'd10204,  18'd9631,
    18'd9091,   18'd8581,   18'd8099,   18'd7645,   18'd7215,   18'd6810,
    18'd6428,   18'd6067,   18'd5727,   18'd5405,   18'd5102,   18'd4816,
    18'd4545,   18'd4290,   18'd4050,   18'd3822,   18'd3608,   18'd3405,
    18'd3214,   18'd3034,   18'd2863,   18'd2703,   18'd2551,   18'd2408,
    18'd2273,   18'd2145,   18'd2025,   18'd1911,   18'd1804,   18'd1703,
    18'd1607,   18'd1517,   18'd1432,   18'd1351,   18'd1276,   18'd1204,
    18'd1136,   18'd1073,   18'd1012,   18'd956,    18'd902,    18'd851,
    18'd804,    18'd758,    18'd716,    18'd676,    18'd638,    18'd602,
    18'd568,    18'd536,    18'd506,    18'd478,    18'd451,    18'd426,
    18'd402,    18'd379,    18'd358,    18'd338,    18'd319,    18'd301,
    18'd284,    18'd268,    18'd253,    18'd239,    18'd225,    18'd213,
    18'd201,    18'd190
  };

  function automatic logic [PER_W-1:0] note_period(logic [NOTE_W-1:0] note);
    logic [NOTE_W-1:0] idx;
    idx = (note < LOW_NOTE) ? '0 : note - LOW_NOTE;
    return PERIOD_ROM[idx];
  endfunction

endpackage

/* rtl/mtv_front.sv */
// Front end: MIDI byte parser that turns each beat into a drive command.
// Depends on mtv_pkg.
module mtv_front
  import mtv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       in_op,
  input  logic [7:0] in_midi_byte,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NOTE,
    PH_VEL
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [NOTE_W-1:0] pend_r, pend_nxt;

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    cmd.kind  = CMD_NONE;
    cmd.note  = pend_r;
    cmd.ev    = EV_NONE;
    if (in_op) begin
      cmd.kind = CMD_TICK;
    end else begin
      unique case (phase_r)
        PH_NOTE: begin
          pend_nxt  = in_midi_byte[NOTE_W-1:0];
          phase_nxt = PH_VEL;
        end
        PH_VEL: begin
          phase_nxt = PH_IDLE;
          if (in_midi_byte == 8'd0) begin
            cmd.kind = CMD_RELEASE;
            cmd.ev   = EV_RELEASED;
          end else begin
            cmd.kind = CMD_PLACE;
            cmd.ev   = EV_PLACED;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (in_midi_byte[7:4] == SYS_NIBBLE) begin
            cmd.ev = EV_SYSTEM;
          end else if (in_midi_byte == NOTE_ON) begin
            phase_nxt = PH_NOTE;
          end else begin
            cmd.ev = EV_UNKNOWN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pend_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

/* rtl/mtv_cmd_fifo.sv */
// Short command queue between parser and drive engine.
// Depends on mtv_pkg.
module mtv_cmd_fifo
  import mtv_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      wr_cmd,
  input  logic      pop,
  output cmd_t      rd_cmd,
  output q_status_t status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign rd_cmd       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("command queue over-filled");

endmodule

/* rtl/mtv_back.sv */
// Back end: drive allocation, period counters and the output register.
// Depends on mtv_pkg (command type, period table).
module mtv_back
  import mtv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [NOTE_W-1:0] split_note,
  input  logic              cmd_avail,
  input  cmd_t              cmd,
  output logic              take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_step_low_drive,
  output logic              out_step_high_drive,
  output logic              out_low_drive_on,
  output logic [NOTE_W-1:0] out_low_drive_note,
  output logic              out_high_drive_on,
  output logic [NOTE_W-1:0] out_high_drive_note,
  output logic [2:0]        out_event_res
);

  logic [1:0]        act_r, act_nxt;
  logic [NOTE_W-1:0] note_r [2];
  logic [NOTE_W-1:0] note_nxt [2];
  logic [PER_W-1:0]  cnt_r [2];
  logic [PER_W-1:0]  cnt_nxt [2];
  logic [1:0]        step;
  logic              valid_r;
  logic [1:0]        step_r;
  event_t            ev_r;

  assign take = cmd_avail && (!valid_r || !out_stall);

  always_comb begin
    logic [PER_W-1:0] per;
    logic [PER_W-1:0] c1;
    logic             sel;
    act_nxt  = act_r;
    note_nxt = note_r;
    cnt_nxt  = cnt_r;
    step     = '0;
    per      = '0;
    c1       = '0;
    sel      = 1'b0;
    unique case (cmd.kind)
      CMD_TICK: begin
        for (int d = 0; d < 2; d++) begin
          per = note_period(note_r[d]);
          c1  = cnt_r[d] + 1'b1;
          if (act_r[d]) begin
            step[d]    = (cnt_r[d] == '0);
            cnt_nxt[d] = (c1 >= per) ? '0 : c1;
          end
        end
      end
      CMD_RELEASE: begin
        if (act_r[0] && note_r[0] == cmd.note) begin
          act_nxt[0] = 1'b0;
          cnt_nxt[0] = '0;
        end else if (act_r[1] && note_r[1] == cmd.note) begin
          act_nxt[1] = 1'b0;
          cnt_nxt[1] = '0;
        end
      end
      CMD_PLACE: begin
        if (cmd.note > split_note) begin
          sel = !act_r[1];
        end else begin
          sel = act_r[0];
        end
        act_nxt[sel]  = 1'b1;
        note_nxt[sel] = cmd.note;
        cnt_nxt[sel]  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= '0;
      note_r  <= '{default: '0};
      cnt_r   <= '{default: '0};
      valid_r <= 1'b0;
    end else if (take) begin
      act_r   <= act_nxt;
      note_r  <= note_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      step_r <= step;
      ev_r   <= cmd.ev;
    end
  end

  assign out_valid           = valid_r;
  assign out_step_low_drive  = step_r[0];
  assign out_step_high_drive = step_r[1];
  assign out_low_drive_on    = act_r[0];
  assign out_low_drive_note  = note_r[0];
  assign out_high_drive_on   = act_r[1];
  assign out_high_drive_note = note_r[1];
  assign out_event_res       = ev_r;

  a_step_low_on: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && step_r[0] |-> act_r[0])
    else $error("low drive stepped while silent");

  a_step_high_on: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && step_r[1] |-> act_r[1])
    else $error("high drive stepped while silent");

  a_step_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (step_r != '0) |-> ev_r == EV_NONE)
    else $error("step pulse on a MIDI beat");

  a_place_sounds: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && ev_r == EV_PLACED |-> act_r != '0)
    else $error("placed note left both drives silent");

endmodule

/* rtl/midi_two_voice_step_tone_player.sv */
// Top level of the two-voice step-tone player: parser, command queue, drive engine.
// Depends on mtv_pkg, mtv_front, mtv_cmd_fifo and mtv_back.
//
// One beat in, one beat out: every accepted MIDI byte or microsecond tick yields exactly
// one result beat showing both drives' state after it. The block takes one beat per clock
// while in_stall is low; a beat crosses the parser into a QUEUE_DEPTH-entry command queue
// and leaves through the drive engine's output register. in_stall rises only once the
// queue is full, which needs an output stall. The period table is a constant lookup;
// split_note is written through the cfg port, which is always ready, and resets to 55.
module midi_two_voice_step_tone_player
  import mtv_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [7:0]        in_midi_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_step_low_drive,
  output logic              out_step_high_drive,
  output logic              out_low_drive_on,
  output logic [NOTE_W-1:0] out_low_drive_note,
  output logic              out_high_drive_on,
  output logic [NOTE_W-1:0] out_high_drive_note,
  output logic [2:0]        out_event_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [NOTE_W-1:0] cfg_data
);

  logic [NOTE_W-1:0] split_r;
  logic              accept;
  logic              take;
  cmd_t              front_cmd;
  cmd_t              q_cmd;
  q_status_t         q_stat;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r <= SPLIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      split_r <= cfg_data;
    end
  end

  mtv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_op        (in_op),
    .in_midi_byte (in_midi_byte),
    .cmd          (front_cmd)
  );

  mtv_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (accept),
    .wr_cmd (front_cmd),
    .pop    (take),
    .rd_cmd (q_cmd),
    .status (q_stat)
  );

  mtv_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .split_note          (split_r),
    .cmd_avail           (!q_stat.empty),
    .cmd                 (q_cmd),
    .take                (take),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_step_low_drive  (out_step_low_drive),
    .out_step_high_drive (out_step_high_drive),
    .out_low_drive_on    (out_low_drive_on),
    .out_low_drive_note  (out_low_drive_note),
    .out_high_drive_on   (out_high_drive_on),
    .out_high_drive_note (out_high_drive_note),
    .out_event_res       (out_event_res)
  );

endmodule
